// ===== rtl/core/sobel_edge_magnitude_rgb_assert.svh =====
// assertion helpers for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// condition on this edge implies a condition on the same edge
`define SEM_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition on this edge implies a condition on the next edge
`define SEM_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/sem_pkg.sv =====
`default_nettype none
package sem_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int HEIGHT_LIMIT = 2048;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int DIM_W        = 12;
   localparam int ROOT_W       = 11;
   localparam int SUM_W        = 22;
   localparam int GRAD_W       = 11;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [7:0]       EDGE_MAX     = 8'd255;

   // register indexes of the configuration port
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

   // input op codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef logic [23:0] pixel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_SQUARE,
      ST_ROOT,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic step;
      logic square;
      logic iterate;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic emit;
      logic root_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/sem_ctrl.sv =====
`default_nettype none
module sem_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  sem_pkg::status_type status,
   output sem_pkg::cmd_type    cmd
);
   import sem_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !status.drop) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.step = 1'b1;
            state_in = status.emit ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.iterate = 1'b1;
            if (status.root_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/sem_datapath.sv =====
`default_nettype none
module sem_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   input  wire  [1:0]          csr_index,
   input  wire  [11:0]         csr_data,
   input  wire                 req_op,
   input  wire  [7:0]          req_red_in,
   input  wire  [7:0]          req_green_in,
   input  wire  [7:0]          req_blue_in,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [7:0]          rsp_red_edge,
   output logic [7:0]          rsp_green_edge,
   output logic [7:0]          rsp_blue_edge,
   output logic                rsp_frame_last,
   input  sem_pkg::cmd_type    cmd,
   output sem_pkg::status_type status
);
   import sem_pkg::*;

   // configuration and frame position
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [ADDR_W-1:0] in_col_ff, out_col_ff;
   logic [DIM_W-1:0]  in_row_ff;
   logic [ADDR_W-1:0] out_row_ff;
   logic              in_frame;
   logic              cfg_write;

   // line stores and window
   pixel_type         row_above_mem [MAX_WIDTH];
   pixel_type         row_two_above_mem [MAX_WIDTH];
   pixel_type         win_ff [6];
   pixel_type         pix_ff, top_ff, mid_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] col_clamp;

   // arithmetic
   logic signed [GRAD_W-1:0] gx_ff [3];
   logic signed [GRAD_W-1:0] gy_ff [3];
   logic signed [GRAD_W-1:0] gx_in [3];
   logic signed [GRAD_W-1:0] gy_in [3];
   logic [SUM_W-1:0]  sum_ff [3];
   logic [ROOT_W-1:0] root_ff [3];
   logic [3:0]        bit_ff;
   logic              last_ff;
   logic [7:0]        edge_in [3];

   logic              mask_top, mask_bot, mask_left, mask_right, emit, last;
   logic [DIM_W-1:0]  col_next;

   assign cfg_write = csr_valid &&
                      (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);

   // effective frame size
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(HEIGHT_LIMIT)) h_eff = DIM_W'(HEIGHT_LIMIT);
   end

   assign in_frame  = in_row_ff < h_eff;
   assign col_clamp = ({1'b0, in_col_ff} >= w_eff) ? ADDR_W'(w_eff - 1'b1) : in_col_ff;
   assign col_next  = {1'b0, addr_ff} + 1'b1;

   assign mask_top   = out_row_ff == '0;
   assign mask_bot   = {1'b0, out_row_ff} == h_eff - 1'b1;
   assign mask_left  = out_col_ff == '0;
   assign mask_right = {1'b0, out_col_ff} == w_eff - 1'b1;
   assign last       = mask_bot && mask_right;
   assign emit       = (in_row_ff >= DIM_W'(2)) || (in_row_ff == DIM_W'(1) && in_col_ff != '0);

   assign status.drop      = (req_op == OP_FLUSH) && in_frame;
   assign status.emit      = emit;
   assign status.root_done = bit_ff == '0;
   assign status.out_free  = !rsp_valid || rsp_ready;

   // line store access
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         top_ff <= row_two_above_mem[addr_ff];
         mid_ff <= row_above_mem[addr_ff];
      end
      if (cmd.step) begin
         row_two_above_mem[addr_ff] <= mid_ff;
         row_above_mem[addr_ff]     <= pix_ff;
      end
   end

   // sobel gradients of the masked neighborhood
   always_comb begin
      logic [7:0] p [9];
      pixel_type  src;
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               if (k == 0) src = win_ff[r];
               else if (k == 1) src = win_ff[3 + r];
               else if (r == 0) src = top_ff;
               else if (r == 1) src = mid_ff;
               else src = pix_ff;
               if ((r == 0 && mask_top) || (r == 2 && mask_bot) ||
                   (k == 0 && mask_left) || (k == 2 && mask_right)) begin
                  p[r * 3 + k] = '0;
               end else begin
                  p[r * 3 + k] = src[16 - 8 * ch +: 8];
               end
            end
         end
         gx_in[ch] = GRAD_W'(signed'({3'b0, p[2]} + {2'b0, p[5], 1'b0} + {3'b0, p[8]}))
                   - GRAD_W'(signed'({3'b0, p[0]} + {2'b0, p[3], 1'b0} + {3'b0, p[6]}));
         gy_in[ch] = GRAD_W'(signed'({3'b0, p[6]} + {2'b0, p[7], 1'b0} + {3'b0, p[8]}))
                   - GRAD_W'(signed'({3'b0, p[0]} + {2'b0, p[1], 1'b0} + {3'b0, p[2]}));
      end
   end

   // rounding and clamping of the root
   always_comb begin
      logic [SUM_W-1:0]  bound;
      logic [ROOT_W:0]   n;
      for (int ch = 0; ch < 3; ch++) begin
         bound = SUM_W'(root_ff[ch]) * SUM_W'(root_ff[ch]) + SUM_W'(root_ff[ch]);
         n     = {1'b0, root_ff[ch]} + ((sum_ff[ch] > bound) ? 1'b1 : 1'b0);
         edge_in[ch] = (n > (ROOT_W + 1)'(EDGE_MAX)) ? EDGE_MAX : n[7:0];
      end
   end

   // gradient, square and root registers
   always_ff @(posedge clock) begin
      logic [ROOT_W-1:0] t;
      if (cmd.capture) begin
         addr_ff <= col_clamp;
         pix_ff  <= in_frame ? {req_red_in, req_green_in, req_blue_in} : '0;
      end
      if (cmd.step) begin
         last_ff <= last;
         for (int ch = 0; ch < 3; ch++) begin
            gx_ff[ch] <= gx_in[ch];
            gy_ff[ch] <= gy_in[ch];
         end
      end
      if (cmd.square) begin
         bit_ff <= 4'(ROOT_W - 1);
         for (int ch = 0; ch < 3; ch++) begin
            sum_ff[ch]  <= SUM_W'(SUM_W'(gx_ff[ch]) * SUM_W'(gx_ff[ch]))
                         + SUM_W'(SUM_W'(gy_ff[ch]) * SUM_W'(gy_ff[ch]));
            root_ff[ch] <= '0;
         end
      end
      if (cmd.iterate) begin
         bit_ff <= bit_ff - 1'b1;
         for (int ch = 0; ch < 3; ch++) begin
            t = root_ff[ch] | (ROOT_W'(1) << bit_ff);
            if (SUM_W'(t) * SUM_W'(t) <= sum_ff[ch]) root_ff[ch] <= t;
         end
      end
   end

   // configuration, window and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (cfg_write) begin
         if (csr_index == REG_FRAME_WIDTH) width_ff <= csr_data;
         else height_ff <= csr_data;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (cmd.step) begin
         if (emit && last) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            for (int i = 0; i < 6; i++) win_ff[i] <= '0;
         end else begin
            if (emit) begin
               if ({1'b0, out_col_ff} + 1'b1 >= w_eff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 1'b1;
               end else begin
                  out_col_ff <= out_col_ff + 1'b1;
               end
            end
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_ff;
            win_ff[4] <= mid_ff;
            win_ff[5] <= pix_ff;
            if (col_next >= w_eff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 1'b1;
            end else begin
               in_col_ff <= col_next[ADDR_W-1:0];
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_red_edge   <= edge_in[0];
         rsp_green_edge <= edge_in[1];
         rsp_blue_edge  <= edge_in[2];
         rsp_frame_last <= last_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// flow: a new item is taken only once the previous one is finished; an item that gives a result
//   goes through the gradient, square, 11-step square root (shared by the three channels) and
//   rounding states, waiting there until the output is free; an early flush is dropped in idle
// reset: synchronous, active high; size returns to 640x480 and position to frame start,
//   line store contents stay undefined until written
`default_nettype none
module sobel_edge_magnitude_rgb (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [11:0] csr_data,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_op,
   input  wire  [7:0]  req_red_in,
   input  wire  [7:0]  req_green_in,
   input  wire  [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_red_edge,
   output logic [7:0]  rsp_green_edge,
   output logic [7:0]  rsp_blue_edge,
   output logic        rsp_frame_last
);
   import sem_pkg::*;

`include "sobel_edge_magnitude_rgb_assert.svh"

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line stores, window and arithmetic
   sem_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_op         (req_op),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_edge   (rsp_red_edge),
      .rsp_green_edge (rsp_green_edge),
      .rsp_blue_edge  (rsp_blue_edge),
      .rsp_frame_last (rsp_frame_last),
      .cmd            (cmd),
      .status         (status)
   );

   // checks
   `SEM_ASSERT_SAME(a_load_free, clock, reset, cmd.load_out, status.out_free, "output overwritten")
   `SEM_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp_valid, "loaded item not shown")
   `SEM_ASSERT_NEXT(a_quiet_step, clock, reset, cmd.step && !status.emit, req_ready, "stuck after step")
   `SEM_ASSERT_SAME(a_busy_root, clock, reset, cmd.iterate, !req_ready, "item taken while busy")

endmodule
`default_nettype wire
